// ----- design/md5_pkg.sv -----
// Shared types, constants and helper functions of the MD5 digest core.
package md5_pkg;

   localparam int COUNT_W = 61;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [31:0] SINE_TAB [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] SHIFT_TAB [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   typedef logic [3:0][31:0] chain_type;

   // Kind of whole word written into the block buffer while padding.
   typedef enum logic [1:0] {
      KIND_MARK   = 2'd0,
      KIND_ZERO   = 2'd1,
      KIND_LEN_LO = 2'd2,
      KIND_LEN_HI = 2'd3
   } word_kind_type;

   typedef struct packed {
      logic          byte_we;
      logic          word_we;
      logic [5:0]    pos;
      logic [7:0]    data;
      logic [3:0]    waddr;
      word_kind_type kind;
      logic [63:0]   len_bits;
   } buf_wr_type;

   typedef struct packed {
      logic start;
      logic init;
   } eng_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } eng_stat_type;

   // Message word used by a given round.
   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [3:0] lo;
      logic [3:0] idx;
      lo = rnd[3:0];
      case (rnd[5:4])
         2'd0: idx = lo;
         2'd1: idx = 4'((lo << 2) + lo + 4'd1);
         2'd2: idx = 4'((lo << 1) + lo + 4'd5);
         2'd3: idx = 4'((lo << 3) - lo);
         default: idx = lo;
      endcase
      return idx;
   endfunction

   function automatic logic [31:0] bswap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

// ----- design/md5_stream_if.sv -----
// Valid/ready channel interfaces for the request bytes and the digest result.
interface md5_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output has_byte,
                   output end_of_message, input ready);
   modport sink (input valid, input data_byte, input has_byte,
                 input end_of_message, output ready);
endinterface

interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_first_half;
   logic [63:0] digest_second_half;

   modport source (output valid, output digest_first_half,
                   output digest_second_half, input ready);
   modport sink (input valid, input digest_first_half,
                 input digest_second_half, output ready);
endinterface

// ----- design/md5_blk_buf.sv -----
// Sixteen-word block buffer memory with byte packing and padding word build.
module md5_blk_buf
   import md5_pkg::*;
(
   input  logic        clock,
   input  buf_wr_type  wr,
   input  logic [3:0]  raddr,
   output logic [31:0] rdata
);

   logic [31:0] mem [16];
   logic [23:0] acc_ff;
   logic [23:0] acc_in;
   logic [31:0] rdata_ff;
   logic [31:0] mark_word;
   logic [31:0] pad_word;
   logic        mem_we;
   logic [3:0]  mem_addr;
   logic [31:0] mem_data;

   // Earlier bytes of the current word, then the 0x80 marker, then zeros.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (2'(k) < wr.pos[1:0] && k < 3) begin
            mark_word[k*8 +: 8] = acc_ff[(k % 3)*8 +: 8];
         end else if (2'(k) == wr.pos[1:0]) begin
            mark_word[k*8 +: 8] = PAD_MARK;
         end else begin
            mark_word[k*8 +: 8] = 8'h00;
         end
      end
   end

   always_comb begin
      case (wr.kind)
         KIND_MARK:   pad_word = mark_word;
         KIND_ZERO:   pad_word = '0;
         KIND_LEN_LO: pad_word = wr.len_bits[31:0];
         KIND_LEN_HI: pad_word = wr.len_bits[63:32];
         default:     pad_word = '0;
      endcase
   end

   always_comb begin
      acc_in   = acc_ff;
      mem_we   = 1'b0;
      mem_addr = wr.waddr;
      mem_data = pad_word;
      if (wr.byte_we) begin
         mem_addr = wr.pos[5:2];
         mem_data = {wr.data, acc_ff};
         case (wr.pos[1:0])
            2'd0: acc_in[7:0]   = wr.data;
            2'd1: acc_in[15:8]  = wr.data;
            2'd2: acc_in[23:16] = wr.data;
            2'd3: mem_we        = 1'b1;
            default: acc_in     = acc_ff;
         endcase
      end else if (wr.word_we) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (mem_we) begin
         mem[mem_addr] <= mem_data;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/md5_rnd_eng.sv -----
// MD5 compression engine: one round per cycle, message words from the buffer.
module md5_rnd_eng
   import md5_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  eng_ctl_type  ctl,
   input  logic [31:0]  m_word,
   output logic [3:0]   rd_addr,
   output eng_stat_type stat,
   output chain_type    chain
);

   typedef enum logic [3:0] {
      ENG_IDLE  = 4'b0001,
      ENG_PRIME = 4'b0010,
      ENG_ROUND = 4'b0100,
      ENG_FOLD  = 4'b1000
   } eng_state_type;

   eng_state_type state_ff, state_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] a_in, b_in, c_in, d_in;
   chain_type   cv_ff, cv_in;
   logic [31:0] f_val;
   logic [31:0] sum;
   logic [63:0] dbl;
   logic [4:0]  shamt;

   always_comb begin
      case (rnd_ff[5:4])
         2'd0:    f_val = d_ff ^ (b_ff & (c_ff ^ d_ff));
         2'd1:    f_val = c_ff ^ (d_ff & (b_ff ^ c_ff));
         2'd2:    f_val = b_ff ^ c_ff ^ d_ff;
         2'd3:    f_val = c_ff ^ (b_ff | ~d_ff);
         default: f_val = '0;
      endcase
      sum   = f_val + a_ff + SINE_TAB[rnd_ff] + m_word;
      shamt = SHIFT_TAB[{rnd_ff[5:4], rnd_ff[1:0]}];
      dbl   = {sum, sum} << shamt;
   end

   // The read for round r+1 goes out while round r computes.
   assign rd_addr = msg_index((state_ff == ENG_ROUND) ? rnd_ff + 6'd1 : 6'd0);

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      cv_in    = cv_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (ctl.init) begin
               cv_in = {IV_D, IV_C, IV_B, IV_A};
            end
            if (ctl.start) begin
               a_in     = cv_ff[0];
               b_in     = cv_ff[1];
               c_in     = cv_ff[2];
               d_in     = cv_ff[3];
               state_in = ENG_PRIME;
            end
         end
         ENG_PRIME: begin
            rnd_in   = '0;
            state_in = ENG_ROUND;
         end
         ENG_ROUND: begin
            a_in   = d_ff;
            d_in   = c_ff;
            c_in   = b_ff;
            b_in   = b_ff + dbl[63:32];
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = ENG_FOLD;
            end
         end
         ENG_FOLD: begin
            cv_in[0] = cv_ff[0] + a_ff;
            cv_in[1] = cv_ff[1] + b_ff;
            cv_in[2] = cv_ff[2] + c_ff;
            cv_in[3] = cv_ff[3] + d_ff;
            state_in = ENG_IDLE;
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         rnd_ff   <= '0;
         cv_ff    <= {IV_D, IV_C, IV_B, IV_A};
         a_ff     <= '0;
         b_ff     <= '0;
         c_ff     <= '0;
         d_ff     <= '0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         cv_ff    <= cv_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         c_ff     <= c_in;
         d_ff     <= d_in;
      end
   end

   assign stat.busy = (state_ff != ENG_IDLE);
   assign stat.done = (state_ff == ENG_FOLD);
   assign chain     = cv_ff;

endmodule

// ----- design/md5_message_digest_core.sv -----
// Top level of the MD5 digest core: byte intake, padding control and result register.
// The core takes one message byte per beat and returns the 128-bit MD5 digest
// after the beat flagged end_of_message. Bytes within a 64-byte block are taken
// back to back, one per cycle; the beat that completes a block holds off the next
// beat while the single round unit runs the 64 rounds, one per cycle, fed by the
// one read port of the block buffer (a prime step issues the first read, and a fold
// step adds the result into the chaining value). At the end of a message the core
// writes the padding and length words, compresses once more, or twice when fewer
// than 9 bytes of the last block are free, and loads the digest into the result
// register once it is free; the first byte of the next message is taken in the
// cycle after that, even while the digest still waits to be taken.
module md5_message_digest_core
   import md5_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   md5_req_if.sink    req_bus,
   md5_rsp_if.source  rsp_bus
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_HASH    = 5'b00010,
      S_PAD     = 5'b00100,
      S_PADHASH = 5'b01000,
      S_DONE    = 5'b10000
   } core_state_type;

   core_state_type state_ff, state_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0]   widx_ff, widx_in;
   logic         extra_ff, extra_in;
   logic         eom_ff, eom_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [63:0]  first_ff, first_in;
   logic [63:0]  second_ff, second_in;
   logic         req_ready;
   logic         accept;
   logic [5:0]   pos;
   logic         len_fits;
   buf_wr_type   buf_wr;
   eng_ctl_type  eng_ctl;
   eng_stat_type eng_stat;
   logic [3:0]   rd_addr;
   logic [31:0]  m_word;
   chain_type    chain;

   md5_blk_buf u_buf (
      .clock (clock),
      .wr    (buf_wr),
      .raddr (rd_addr),
      .rdata (m_word)
   );

   md5_rnd_eng u_eng (
      .clock   (clock),
      .reset   (reset),
      .ctl     (eng_ctl),
      .m_word  (m_word),
      .rd_addr (rd_addr),
      .stat    (eng_stat),
      .chain   (chain)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_bus.valid && req_ready;
   assign pos       = cnt_ff[5:0];
   // The length words fit behind the marker only when it lands before byte 56.
   assign len_fits  = (cnt_ff[5:3] != 3'b111);

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      widx_in         = widx_ff;
      extra_in        = extra_ff;
      eom_in          = eom_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      first_in        = first_ff;
      second_in       = second_ff;
      eng_ctl         = '0;
      buf_wr.byte_we  = 1'b0;
      buf_wr.word_we  = 1'b0;
      buf_wr.pos      = pos;
      buf_wr.data     = req_bus.data_byte;
      buf_wr.waddr    = widx_ff;
      buf_wr.kind     = KIND_ZERO;
      buf_wr.len_bits = {cnt_ff, 3'b000};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               extra_in = 1'b0;
               if (req_bus.has_byte) begin
                  buf_wr.byte_we = 1'b1;
                  cnt_in         = cnt_ff + COUNT_W'(1);
                  if (pos == 6'd63) begin
                     eng_ctl.start = 1'b1;
                     eom_in        = req_bus.end_of_message;
                     state_in      = S_HASH;
                  end else if (req_bus.end_of_message) begin
                     widx_in  = cnt_in[5:2];
                     state_in = S_PAD;
                  end
               end else if (req_bus.end_of_message) begin
                  widx_in  = pos[5:2];
                  state_in = S_PAD;
               end
            end
         end
         S_HASH: begin
            if (eng_stat.done) begin
               if (eom_ff) begin
                  widx_in  = '0;
                  state_in = S_PAD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PAD: begin
            buf_wr.word_we = 1'b1;
            if (!extra_ff && widx_ff == pos[5:2]) begin
               buf_wr.kind = KIND_MARK;
            end else if ((extra_ff || len_fits) && widx_ff == 4'd14) begin
               buf_wr.kind = KIND_LEN_LO;
            end else if ((extra_ff || len_fits) && widx_ff == 4'd15) begin
               buf_wr.kind = KIND_LEN_HI;
            end
            if (widx_ff == 4'd15) begin
               eng_ctl.start = 1'b1;
               state_in      = S_PADHASH;
            end else begin
               widx_in = widx_ff + 4'd1;
            end
         end
         S_PADHASH: begin
            if (eng_stat.done) begin
               if (!extra_ff && !len_fits) begin
                  extra_in = 1'b1;
                  widx_in  = '0;
                  state_in = S_PAD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               first_in     = {bswap32(chain[0]), bswap32(chain[1])};
               second_in    = {bswap32(chain[2]), bswap32(chain[3])};
               rsp_valid_in = 1'b1;
               eng_ctl.init = 1'b1;
               cnt_in       = '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         widx_ff      <= '0;
         extra_ff     <= 1'b0;
         eom_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         widx_ff      <= widx_in;
         extra_ff     <= extra_in;
         eom_ff       <= eom_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      second_ff <= second_in;
   end

   assign req_bus.ready              = req_ready;
   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.digest_first_half  = first_ff;
   assign rsp_bus.digest_second_half = second_ff;

`ifndef SYNTHESIS
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      eng_stat.done |-> (state_ff == S_HASH || state_ff == S_PADHASH))
      else $error("compression finished while the control was not waiting for it");

   a_ready_engine_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !eng_stat.busy)
      else $error("input open while the round engine is busy");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result beat raised outside the digest load");

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && $past(state_ff == S_DONE)) |-> (cnt_ff == '0))
      else $error("byte count not cleared after a digest");
`endif

endmodule
